FILE: rtl/core/sfrd_pkg.sv
// Package for the file receive deframer: transaction structs, codes and tag words.
// No dependencies; imported by sync_file_receive_deframer.
package sfrd_pkg;

   localparam logic [31:0] TAG_DATA = 32'h4154_4144;
   localparam logic [31:0] TAG_DONE = 32'h454E_4F44;
   localparam logic [31:0] TAG_FAIL = 32'h4C49_4146;

   localparam logic [31:0] HEADER_LEN = 32'd8;

   typedef enum logic [1:0] {
      OP_OPEN  = 2'd0,
      OP_START = 2'd1,
      OP_BYTE  = 2'd2,
      OP_CLOSE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      K_BYTE   = 3'd0,
      K_EOF    = 3'd1,
      K_FAIL   = 3'd2,
      K_OPENED = 3'd3,
      K_NOSLOT = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_FREE     = 3'd0,
      PH_OPEN     = 3'd1,
      PH_HEADER   = 3'd2,
      PH_DATA     = 3'd3,
      PH_FAILDATA = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      MT_DATA = 2'd0,
      MT_DONE = 2'd1,
      MT_FAIL = 2'd2
   } mtag_type;

   typedef struct packed {
      op_type      opcode;
      logic [1:0]  slot;
      logic [7:0]  rx_byte;
      logic        chunk_end;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  out_slot;
      logic [7:0]  payload_byte;
      logic        close_channel;
      logic        last;
   } rsp_type;

endpackage

FILE: rtl/core/sync_file_receive_deframer.sv
// File receive deframer top level: input register, per-slot parser, result queue.
// Depends on sfrd_pkg.
//
// The block accepts one transaction per cycle on the req channel while req_ready is
// high. Each accepted transaction is held in an input register and handled, once the
// result queue holds at most two entries, by a single read-modify-write of one slot's
// state (the addressed slot, or the lowest free slot for an open: phase, remaining
// count, header bytes, message tag, drop flag), which pushes zero, one or two results
// into a four-entry result queue; results leave on the rsp channel one per cycle while
// rsp_ready is high, so the first result of a transaction passes the input register
// and the result queue before it is offered. Items that give at most one result
// sustain one per cycle while rsp_ready holds; a payload byte that also ends the file
// gives two, and the single rsp port then sets the pace. Per-slot header bytes have no reset.
module sync_file_receive_deframer
   import sfrd_pkg::*;
#(
   parameter int SLOTS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int QDEPTH = 4;
   localparam int PTR_W  = 2;
   localparam int CNT_W  = 3;

   req_type           in_ff;
   logic              in_valid_ff;
   logic              in_valid_in;

   phase_type         phase_ff   [SLOTS];
   logic [31:0]       remain_ff  [SLOTS];
   logic [63:0]       header_ff  [SLOTS];
   mtag_type          mtag_ff    [SLOTS];
   logic              drop_ff    [SLOTS];

   rsp_type           queue_ff   [QDEPTH];
   logic [PTR_W-1:0]  head_ff;
   logic [PTR_W-1:0]  tail_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [PTR_W-1:0]  head_in;
   logic [PTR_W-1:0]  tail_in;
   logic [CNT_W-1:0]  count_in;

   logic              fire;
   logic              pop;
   logic              slot_ok;
   logic [SLOT_W-1:0] sidx;
   logic [SLOT_W-1:0] open_idx;
   logic              open_found;

   phase_type         phase_in;
   logic [31:0]       remain_in;
   logic [63:0]       header_in;
   mtag_type          mtag_in;
   logic              drop_in;
   logic              wr_en;
   logic              hdr_wr;
   logic [SLOT_W-1:0] wr_idx;

   logic [2:0]        pos;
   logic [31:0]       tag_word;
   logic [31:0]       len_word;
   logic              data_done;
   logic              finish;
   kind_type          finish_kind;
   logic [1:0]        n_res;
   rsp_type           res0;
   rsp_type           res1;

   assign fire      = in_valid_ff && (count_ff <= CNT_W'(QDEPTH - 2));
   assign req_ready = !in_valid_ff || fire;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_payload = queue_ff[head_ff];

   assign slot_ok = (32'(in_ff.slot) < 32'(SLOTS));
   assign sidx    = SLOT_W'(in_ff.slot);

   always_comb begin
      open_found = 1'b0;
      open_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (phase_ff[i] == PH_FREE || 3'(phase_ff[i]) > 3'(PH_FAILDATA)) begin
            open_found = 1'b1;
            open_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      phase_in    = phase_ff[sidx];
      remain_in   = remain_ff[sidx];
      mtag_in     = mtag_ff[sidx];
      drop_in     = drop_ff[sidx];
      header_in   = header_ff[sidx];
      wr_en       = 1'b0;
      hdr_wr      = 1'b0;
      wr_idx      = sidx;
      data_done   = 1'b0;
      finish      = 1'b0;
      finish_kind = K_FAIL;
      n_res       = 2'd0;
      res0        = '0;
      res1        = '0;
      pos         = 3'd0 - remain_ff[sidx][2:0];
      header_in[{pos, 3'b000} +: 8] = in_ff.rx_byte;
      tag_word    = header_in[31:0];
      len_word    = header_in[63:32];

      unique case (in_ff.opcode)
         OP_OPEN: begin
            n_res = 2'd1;
            if (open_found) begin
               wr_en          = 1'b1;
               wr_idx         = open_idx;
               phase_in       = PH_OPEN;
               remain_in      = '0;
               mtag_in        = MT_DATA;
               drop_in        = drop_ff[open_idx];
               res0.kind      = K_OPENED;
               res0.out_slot  = 2'(open_idx);
            end else begin
               res0.kind      = K_NOSLOT;
            end
         end
         OP_START: begin
            if (slot_ok && phase_ff[sidx] == PH_OPEN) begin
               wr_en     = 1'b1;
               phase_in  = PH_HEADER;
               remain_in = HEADER_LEN;
            end
         end
         OP_BYTE: begin
            if (slot_ok) begin
               wr_en = 1'b1;
               if (drop_ff[sidx]) begin
                  if (in_ff.chunk_end) begin
                     drop_in = 1'b0;
                  end
               end else begin
                  case (phase_ff[sidx])
                     PH_HEADER: begin
                        hdr_wr = 1'b1;
                        if (remain_ff[sidx] > 32'd1 && remain_ff[sidx] <= HEADER_LEN) begin
                           remain_in = remain_ff[sidx] - 32'd1;
                        end else begin
                           remain_in = len_word;
                           if (tag_word == TAG_DATA || tag_word == TAG_DONE) begin
                              phase_in  = PH_DATA;
                              mtag_in   = (tag_word == TAG_DONE) ? MT_DONE : MT_DATA;
                              data_done = (len_word == '0);
                           end else if (tag_word == TAG_FAIL) begin
                              phase_in  = PH_FAILDATA;
                              mtag_in   = MT_FAIL;
                              finish    = (len_word == '0);
                           end else begin
                              finish    = 1'b1;
                           end
                        end
                     end
                     PH_DATA: begin
                        if (remain_ff[sidx] == '0) begin
                           data_done = 1'b1;
                        end else begin
                           n_res             = 2'd1;
                           res0.kind         = K_BYTE;
                           res0.out_slot     = in_ff.slot;
                           res0.payload_byte = in_ff.rx_byte;
                           remain_in         = remain_ff[sidx] - 32'd1;
                           data_done         = (remain_ff[sidx] == 32'd1);
                        end
                     end
                     PH_FAILDATA: begin
                        if (remain_ff[sidx] > 32'd1) begin
                           remain_in = remain_ff[sidx] - 32'd1;
                        end else begin
                           finish = 1'b1;
                        end
                     end
                     default: begin
                        finish = 1'b1;
                     end
                  endcase
               end
            end
         end
         OP_CLOSE: begin
            if (slot_ok) begin
               wr_en         = 1'b1;
               n_res         = 2'd1;
               res0.kind     = K_FAIL;
               res0.out_slot = in_ff.slot;
               phase_in      = PH_FREE;
               remain_in     = '0;
               mtag_in       = MT_DATA;
               drop_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if (data_done) begin
         if (mtag_in == MT_DONE) begin
            finish      = 1'b1;
            finish_kind = in_ff.chunk_end ? K_EOF : K_FAIL;
         end else begin
            phase_in  = PH_HEADER;
            remain_in = HEADER_LEN;
         end
      end

      if (finish) begin
         phase_in  = PH_FREE;
         remain_in = '0;
         mtag_in   = MT_DATA;
         drop_in   = !in_ff.chunk_end;
         if (n_res == 2'd0) begin
            res0.kind          = finish_kind;
            res0.out_slot      = in_ff.slot;
            res0.close_channel = 1'b1;
         end else begin
            res1.kind          = finish_kind;
            res1.out_slot      = in_ff.slot;
            res1.close_channel = 1'b1;
         end
         n_res = n_res + 2'd1;
      end

      res0.last = (n_res == 2'd1);
      res1.last = 1'b1;
   end

   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            phase_ff[i]  <= PH_FREE;
            remain_ff[i] <= '0;
            mtag_ff[i]   <= MT_DATA;
            drop_ff[i]   <= 1'b0;
         end
      end else if (fire && wr_en) begin
         phase_ff[wr_idx]  <= phase_in;
         remain_ff[wr_idx] <= remain_in;
         mtag_ff[wr_idx]   <= mtag_in;
         drop_ff[wr_idx]   <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && hdr_wr) begin
         header_ff[sidx] <= header_in;
      end
   end

   always_comb begin
      head_in  = pop ? head_ff + PTR_W'(1) : head_ff;
      tail_in  = fire ? tail_ff + PTR_W'(n_res) : tail_ff;
      count_in = count_ff + (fire ? CNT_W'(n_res) : '0) - (pop ? CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && n_res != 2'd0) begin
         queue_ff[tail_ff] <= res0;
      end
      if (fire && n_res == 2'd2) begin
         queue_ff[tail_ff + PTR_W'(1)] <= res1;
      end
   end

endmodule
